@@ hdl/keyed_ordered_record_list_assert.svh @@
// ----------------------------------------------------------------------------
// keyed_ordered_record_list assertion macros
// Shared concurrent assertion forms for the record list design.
// ----------------------------------------------------------------------------
`ifndef KEYED_ORDERED_RECORD_LIST_ASSERT_SVH
`define KEYED_ORDERED_RECORD_LIST_ASSERT_SVH

// property must hold whenever out of reset
`define KORL_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked in every cycle, reset included
`define KORL_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hdl/korl_pkg.sv @@
// ----------------------------------------------------------------------------
// korl_pkg
// Types and codes shared by the record list modules.
// ----------------------------------------------------------------------------
package korl_pkg;

  localparam int unsigned CAPACITY_DEF = 32;
  localparam int unsigned OP_W = 4;
  localparam int unsigned ST_W = 2;
  localparam int unsigned CNT_W = 6;

  localparam logic [OP_W-1:0] OP_CLEAR   = 4'd0;
  localparam logic [OP_W-1:0] OP_INS_HD  = 4'd1;
  localparam logic [OP_W-1:0] OP_INS_TL  = 4'd2;
  localparam logic [OP_W-1:0] OP_INS_AFT = 4'd3;
  localparam logic [OP_W-1:0] OP_RM_HD   = 4'd4;
  localparam logic [OP_W-1:0] OP_RM_TL   = 4'd5;
  localparam logic [OP_W-1:0] OP_RM_KEY  = 4'd6;
  localparam logic [OP_W-1:0] OP_LOOKUP  = 4'd7;
  localparam logic [OP_W-1:0] OP_LIST    = 4'd8;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd2;
  localparam logic [ST_W-1:0] ST_MISSING = 2'd3;

  // one stored record
  typedef struct packed {
    logic [31:0] key;
    logic [31:0] weight;
  } rec_t;

  // one result item
  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [31:0]      key;
    logic [31:0]      weight;
    logic [CNT_W-1:0] occupancy;
    logic             last;
  } res_t;

endpackage

@@ hdl/korl_mem.sv @@
// ----------------------------------------------------------------------------
// korl_mem
// Record store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module korl_mem #(
  parameter int unsigned DEPTH = korl_pkg::CAPACITY_DEF,
  parameter int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  korl_pkg::rec_t  wdata,
  input  logic [AW-1:0]   raddr,
  output korl_pkg::rec_t  rdata
);

  korl_pkg::rec_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port; rdata is registered and follows raddr in the next cycle
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/korl_out.sv @@
// ----------------------------------------------------------------------------
// korl_out
// Output register: holds one result until the consumer takes the transfer.
// ----------------------------------------------------------------------------
module korl_out (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  korl_pkg::res_t push_data,
  output logic           full,
  output logic           out_valid,
  input  logic           out_stall,
  output korl_pkg::res_t out_data
);

  logic valid_r;
  korl_pkg::res_t data_r;

  assign full      = valid_r && out_stall;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (push) begin
      data_r <= push_data;
    end
  end

endmodule

@@ hdl/keyed_ordered_record_list.sv @@
// Clear and decode-time failures respond directly; tail insert writes and then responds;
//   head insert, insert after and the removes first walk or shift the list (n = occupancy
//   sets the length of the walk or shift); list returns one result item per record.
// One operation at a time: in_stall holds off new items while the sequencer is busy,
//   as with the read-then-write of each shift step and the read-then-check key walk.
// Reset: synchronous, active low; occupancy clears, memory contents do not.
`include "keyed_ordered_record_list_assert.svh"
// ----------------------------------------------------------------------------
// keyed_ordered_record_list
// Bounded ordered list of keyed records kept in a synchronous memory.
// ----------------------------------------------------------------------------
module keyed_ordered_record_list #(
  parameter int unsigned CAPACITY = korl_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [korl_pkg::OP_W-1:0]     in_operation,
  input  logic signed [31:0]            in_entry_key,
  input  logic [31:0]                   in_entry_weight,
  input  logic signed [31:0]            in_match_key,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [korl_pkg::ST_W-1:0]     out_status,
  output logic signed [31:0]            out_found_key,
  output logic [31:0]                   out_found_weight,
  output logic [korl_pkg::CNT_W-1:0]    out_occupancy,
  output logic                          out_last
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = korl_pkg::CNT_W + 1;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE, S_SEARCH, S_SHUP, S_SHDN, S_WRITE, S_LIST, S_RESP
  } state_t;

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;      // walking pointer
  logic [CW-1:0] pos_r, pos_nxt;      // target position
  logic [korl_pkg::OP_W-1:0] op_r, op_nxt;
  korl_pkg::rec_t new_r, new_nxt;
  logic [31:0] mkey_r, mkey_nxt;
  logic rd_pend_r, rd_pend_nxt;       // read data valid this cycle
  korl_pkg::res_t res_r, res_nxt;

  logic we;
  logic [AW-1:0] waddr, raddr;
  korl_pkg::rec_t wdata, rdata;
  logic push, ofull;
  korl_pkg::res_t push_data, out_data;

  korl_mem #(.DEPTH(CAPACITY), .AW(AW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  korl_out u_out (
    .clk(clk), .rst_n(rst_n), .push(push), .push_data(push_data),
    .full(ofull), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

  assign out_status       = out_data.status;
  assign out_found_key    = out_data.key;
  assign out_found_weight = out_data.weight;
  assign out_occupancy    = out_data.occupancy;
  assign out_last         = out_data.last;

  assign in_stall = (state_r != S_IDLE);

  function automatic korl_pkg::res_t mk_res(logic [korl_pkg::ST_W-1:0] st,
                                            korl_pkg::rec_t r,
                                            logic [CW-1:0] cnt, logic lst);
    korl_pkg::res_t v;
    v.status    = st;
    v.key       = r.key;
    v.weight    = r.weight;
    v.occupancy = cnt[korl_pkg::CNT_W-1:0];
    v.last      = lst;
    return v;
  endfunction

  // control sequencer
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    pos_nxt     = pos_r;
    op_nxt      = op_r;
    new_nxt     = new_r;
    mkey_nxt    = mkey_r;
    rd_pend_nxt = 1'b0;
    res_nxt     = res_r;
    we          = 1'b0;
    waddr       = idx_r[AW-1:0];
    wdata       = rdata;
    raddr       = idx_r[AW-1:0];
    push        = 1'b0;
    push_data   = res_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_operation;
          new_nxt    = '{key: in_entry_key, weight: in_entry_weight};
          mkey_nxt   = in_match_key;
          res_nxt    = mk_res(korl_pkg::ST_OK, '0, count_r, 1'b1);
          state_nxt  = S_RESP;
          case (in_operation)
            korl_pkg::OP_CLEAR: begin
              count_nxt = '0;
              res_nxt.occupancy = '0;
            end
            korl_pkg::OP_INS_HD, korl_pkg::OP_INS_TL, korl_pkg::OP_INS_AFT: begin
              if (count_r >= CAP_C) begin
                res_nxt.status = korl_pkg::ST_FULL;
              end else if (in_operation == korl_pkg::OP_INS_TL) begin
                pos_nxt = count_r;
                state_nxt = S_WRITE;
              end else if (in_operation == korl_pkg::OP_INS_HD) begin
                pos_nxt = '0;
                idx_nxt = count_r;
                state_nxt = S_SHUP;
              end else if (count_r == '0) begin
                res_nxt.status = korl_pkg::ST_EMPTY;
              end else begin
                idx_nxt = '0;
                state_nxt = S_SEARCH;
              end
            end
            korl_pkg::OP_RM_HD, korl_pkg::OP_RM_TL, korl_pkg::OP_RM_KEY,
            korl_pkg::OP_LOOKUP, korl_pkg::OP_LIST: begin
              if (count_r == '0) begin
                res_nxt.status = korl_pkg::ST_EMPTY;
              end else if (in_operation == korl_pkg::OP_LIST) begin
                idx_nxt = '0;
                state_nxt = S_LIST;
              end else begin
                idx_nxt = (in_operation == korl_pkg::OP_RM_TL) ? count_r - 1'b1 : '0;
                state_nxt = S_SEARCH;
              end
            end
            default: ;
          endcase
        end
      end
      // walk reads; rdata belongs to idx_r-1 when rd_pend_r
      S_SEARCH: begin
        if (!rd_pend_r) begin
          raddr = idx_r[AW-1:0];
          idx_nxt = idx_r + 1'b1;
          rd_pend_nxt = 1'b1;
        end else begin
          if (op_r == korl_pkg::OP_RM_HD || op_r == korl_pkg::OP_RM_TL ||
              rdata.key == mkey_r) begin
            pos_nxt = idx_r - 1'b1;
            res_nxt = mk_res(korl_pkg::ST_OK, rdata, count_r, 1'b1);
            if (op_r == korl_pkg::OP_INS_AFT) begin
              res_nxt = mk_res(korl_pkg::ST_OK, '0, count_r + 1'b1, 1'b1);
              pos_nxt = idx_r;
              idx_nxt = count_r;
              state_nxt = S_SHUP;
            end else if (op_r == korl_pkg::OP_LOOKUP) begin
              state_nxt = S_RESP;
            end else begin
              count_nxt = count_r - 1'b1;
              res_nxt.occupancy = count_nxt[korl_pkg::CNT_W-1:0];
              state_nxt = S_SHDN;
            end
          end else if (idx_r >= count_r) begin
            res_nxt = mk_res(korl_pkg::ST_MISSING, '0, count_r, 1'b1);
            state_nxt = S_RESP;
          end else begin
            raddr = idx_r[AW-1:0];
            idx_nxt = idx_r + 1'b1;
            rd_pend_nxt = 1'b1;
          end
        end
      end
      // shift up: entry i-1 moves to i, i from count down to pos+1
      S_SHUP: begin
        if (idx_r <= pos_r) begin
          state_nxt = S_WRITE;
        end else if (!rd_pend_r) begin
          raddr = AW'(idx_r - 1'b1);
          rd_pend_nxt = 1'b1;
        end else begin
          we = 1'b1;
          waddr = idx_r[AW-1:0];
          idx_nxt = idx_r - 1'b1;
        end
      end
      // shift down: entry pos+1 moves to pos, until the new count
      S_SHDN: begin
        if (pos_r >= count_r) begin
          state_nxt = S_RESP;
        end else if (!rd_pend_r) begin
          raddr = AW'(pos_r + 1'b1);
          rd_pend_nxt = 1'b1;
        end else begin
          we = 1'b1;
          waddr = pos_r[AW-1:0];
          pos_nxt = pos_r + 1'b1;
        end
      end
      S_WRITE: begin
        we = 1'b1;
        waddr = pos_r[AW-1:0];
        wdata = new_r;
        count_nxt = count_r + 1'b1;
        res_nxt = mk_res(korl_pkg::ST_OK, '0, count_nxt, 1'b1);
        state_nxt = S_RESP;
      end
      // list: read ahead, push each record when output has room
      S_LIST: begin
        if (!rd_pend_r) begin
          raddr = idx_r[AW-1:0];
          rd_pend_nxt = 1'b1;
        end else if (!ofull) begin
          push = 1'b1;
          push_data = mk_res(korl_pkg::ST_OK, rdata, count_r,
                             (idx_r + 1'b1) == count_r);
          idx_nxt = idx_r + 1'b1;
          if ((idx_r + 1'b1) == count_r) begin
            state_nxt = S_IDLE;
          end
        end else begin
          rd_pend_nxt = 1'b0;
        end
      end
      S_RESP: begin
        if (!ofull) begin
          push = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      rd_pend_r <= rd_pend_nxt;
    end
    idx_r  <= idx_nxt;
    pos_r  <= pos_nxt;
    op_r   <= op_nxt;
    new_r  <= new_nxt;
    mkey_r <= mkey_nxt;
    res_r  <= res_nxt;
  end

  `KORL_ASSERT(a_count_cap, clk, rst_n, count_r <= CAP_C, "count above capacity")
  `KORL_ASSERT(a_busy_no_take, clk, rst_n, (state_r != S_IDLE) |-> in_stall, "took item while busy")
  `KORL_ASSERT(a_push_room, clk, rst_n, push |-> !ofull, "result pushed into full register")
  `KORL_ASSERT(a_write_cap, clk, rst_n, (state_r == S_WRITE) |-> (count_r < CAP_C), "insert into full list")

endmodule
